>>> rtl/core/htcb_pkg.sv
// Package for the HTML tag and comment blanker.
// Holds the character width, character codes and the structs shared by
// the blanker modules. No dependencies.
`default_nettype none

package htcb_pkg;

    localparam int CHAR_BITS = 16;

    typedef logic [CHAR_BITS-1:0] char_t;

    localparam char_t CH_LT     = char_t'(8'h3C);
    localparam char_t CH_BANG   = char_t'(8'h21);
    localparam char_t CH_DASH   = char_t'(8'h2D);
    localparam char_t CH_GT     = char_t'(8'h3E);
    localparam char_t CH_SQUOTE = char_t'(8'h27);
    localparam char_t CH_DQUOTE = char_t'(8'h22);
    localparam char_t CH_SPACE  = char_t'(8'h20);

    // Parser flags carried from character to character.
    typedef struct packed {
        logic cmt;
        logic tag;
        logic sq;
        logic dq;
    } htcb_flags_t;

    // One character beat with its end-of-text mark.
    typedef struct packed {
        logic  valid;
        char_t code;
        logic  last;
    } htcb_item_t;

endpackage

`default_nettype wire

>>> rtl/core/htcb_blank.sv
// Combinational decision for one character: updates the comment, tag and
// quote flags and picks the original character or a space.
// Depends on htcb_pkg.
`default_nettype none

module htcb_blank (
    input  wire htcb_pkg::char_t      ch,
    input  wire htcb_pkg::char_t      la0,
    input  wire htcb_pkg::char_t      la1,
    input  wire htcb_pkg::char_t      la2,
    input  wire logic                 la_ok,
    input  wire htcb_pkg::char_t      beh0,
    input  wire htcb_pkg::char_t      beh1,
    input  wire logic                 beh_ok,
    input  wire htcb_pkg::htcb_flags_t flags,
    input  wire logic                 blank_tags,
    output htcb_pkg::htcb_flags_t     flags_next,
    output htcb_pkg::char_t           res_code
);
    import htcb_pkg::*;

    logic cmt1;
    logic closed_cmt;
    logic tag1;
    logic closed_tag;
    logic sq1;
    logic dq1;

    always_comb begin
        cmt1       = flags.cmt;
        closed_cmt = 1'b0;
        if (!flags.cmt && !flags.sq && !flags.dq && !flags.tag && la_ok) begin
            if (ch == CH_LT && la0 == CH_BANG && la1 == CH_DASH && la2 == CH_DASH) begin
                cmt1 = 1'b1;
            end
        end else if (flags.cmt && beh_ok) begin
            if (ch == CH_GT && beh0 == CH_DASH && beh1 == CH_DASH) begin
                cmt1       = 1'b0;
                closed_cmt = 1'b1;
            end
        end

        tag1       = flags.tag;
        closed_tag = 1'b0;
        if (!flags.sq && !flags.dq && !cmt1 && !closed_cmt) begin
            if (!flags.tag && ch == CH_LT) begin
                tag1 = 1'b1;
            end else if (flags.tag && ch == CH_GT) begin
                tag1       = 1'b0;
                closed_tag = 1'b1;
            end
        end

        // Quotes only count inside a tag, and one kind masks the other.
        sq1 = flags.sq;
        if (!cmt1 && !flags.dq && tag1 && ch == CH_SQUOTE) begin
            sq1 = !flags.sq;
        end
        dq1 = flags.dq;
        if (!cmt1 && !sq1 && tag1 && ch == CH_DQUOTE) begin
            dq1 = !flags.dq;
        end

        flags_next.cmt = cmt1;
        flags_next.tag = tag1;
        flags_next.sq  = sq1;
        flags_next.dq  = dq1;

        res_code = ch;
        if ((blank_tags && (tag1 || closed_tag)) || cmt1 || closed_cmt) begin
            res_code = CH_SPACE;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/htcb_core.sv
// Lookahead queue, history and flag state of the blanker, plus the
// end-of-text drain sequencer. Emits at most one character per cycle.
// Depends on htcb_pkg and htcb_blank.
`default_nettype none

module htcb_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire htcb_pkg::htcb_item_t in_item,
    input  wire logic                out_ok,
    input  wire logic                blank_tags,
    output logic                     consume,
    output htcb_pkg::htcb_item_t     emit
);
    import htcb_pkg::*;

    char_t       q_reg [0:3];
    logic [2:0]  qn_reg;
    logic [2:0]  qn_next;
    logic        drain_reg;
    logic        drain_next;
    htcb_flags_t flags_reg;
    htcb_flags_t flags_next;
    char_t       beh0_reg;
    char_t       beh1_reg;
    logic [1:0]  beh_cnt_reg;
    logic [1:0]  beh_cnt_next;

    char_t       la2;
    logic        la_ok;
    logic        emit_req;
    logic        do_emit;
    logic        do_store;
    htcb_flags_t blk_flags;
    char_t       blk_code;

    htcb_blank u_blank (
        .ch         (q_reg[0]),
        .la0        (q_reg[1]),
        .la1        (q_reg[2]),
        .la2        (la2),
        .la_ok      (la_ok),
        .beh0       (beh0_reg),
        .beh1       (beh1_reg),
        .beh_ok     (beh_cnt_reg == 2'd2),
        .flags      (flags_reg),
        .blank_tags (blank_tags),
        .flags_next (blk_flags),
        .res_code   (blk_code)
    );

    always_comb begin
        la2      = drain_reg ? q_reg[3] : in_item.code;
        la_ok    = drain_reg ? (qn_reg == 3'd4) : 1'b1;
        emit_req = drain_reg || (in_item.valid && !in_item.last && qn_reg == 3'd3);
        do_emit  = emit_req && out_ok;
        // A beat that only fills the queue needs no output room.
        do_store = !drain_reg && in_item.valid && !emit_req;
        consume  = !drain_reg && in_item.valid && (do_store || do_emit);

        emit.valid = do_emit;
        emit.code  = blk_code;
        emit.last  = drain_reg && qn_reg == 3'd1;

        qn_next      = qn_reg;
        drain_next   = drain_reg;
        flags_next   = flags_reg;
        beh_cnt_next = beh_cnt_reg;
        if (do_emit) begin
            flags_next = blk_flags;
            if (beh_cnt_reg != 2'd2) begin
                beh_cnt_next = beh_cnt_reg + 2'd1;
            end
            if (drain_reg) begin
                qn_next = qn_reg - 3'd1;
                if (qn_reg == 3'd1) begin
                    // Last character of the text: start the next text clean.
                    drain_next   = 1'b0;
                    flags_next   = '0;
                    beh_cnt_next = 2'd0;
                end
            end
        end else if (do_store) begin
            qn_next = qn_reg + 3'd1;
            if (in_item.last) begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qn_reg      <= 3'd0;
            drain_reg   <= 1'b0;
            flags_reg   <= '0;
            beh_cnt_reg <= 2'd0;
        end else begin
            qn_reg      <= qn_next;
            drain_reg   <= drain_next;
            flags_reg   <= flags_next;
            beh_cnt_reg <= beh_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            beh1_reg <= beh0_reg;
            beh0_reg <= q_reg[0];
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
            q_reg[2] <= drain_reg ? q_reg[3] : in_item.code;
        end else if (do_store) begin
            q_reg[qn_reg[1:0]] <= in_item.code;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/html_tag_comment_blanker_unit.sv
// HTML tag and comment blanker, top level. One character beat per cycle
// while the output takes them, set by the single-character decision
// between input and output registers; each output lags its input by three
// characters plus those registers. An end-of-text beat drains up to four
// results, one per cycle as the output takes them; input is held off.
// Synchronous active-low reset clears all flags and queues; blank_tags = 1.
`default_nettype none

module html_tag_comment_blanker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] char_code
    input  wire logic        s_tlast,   // is_final
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] out_code
    output logic             m_tlast,   // out_final
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data   // blank_tags
);
    import htcb_pkg::*;

    logic       blank_tags_reg;
    logic       in_valid_reg;
    char_t      in_code_reg;
    logic       in_last_reg;
    logic       m_valid_reg;
    char_t      m_code_reg;
    logic       m_last_reg;
    logic       out_ok;
    logic       consume;
    logic       s_accept;
    htcb_item_t in_item;
    htcb_item_t emit;

    assign cfg_ready = 1'b1;
    assign out_ok    = !m_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || consume;
    assign s_accept  = s_tvalid && s_tready;

    assign in_item.valid = in_valid_reg;
    assign in_item.code  = in_code_reg;
    assign in_item.last  = in_last_reg;

    htcb_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_item    (in_item),
        .out_ok     (out_ok),
        .blank_tags (blank_tags_reg),
        .consume    (consume),
        .emit       (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_tags_reg <= 1'b1;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                blank_tags_reg <= cfg_data;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (emit.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_code_reg <= char_t'(s_tdata);
            in_last_reg <= s_tlast;
        end
        if (emit.valid) begin
            m_code_reg <= emit.code;
            m_last_reg <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_code_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> test/html_tag_comment_blanker_checker.sv
// Scoreboard for the HTML tag and comment blanker: watches the input, result
// and register channels, predicts each result beat and compares it.
// Depends on htcb_pkg for the character type, codes and parser flags.
`timescale 1ns / 100ps

module html_tag_comment_blanker_checker
    import htcb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] char_code
    input  logic        s_tlast,   // is_final
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] out_code
    input  logic        m_tlast,   // out_final
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,  // blank_tags
    output int          mismatch_count,
    output int          beats_owed
);

    typedef struct packed {
        char_t code;
        logic  last;
    } out_beat_t;

    out_beat_t   owed_q[$];
    int          fail_total;
    logic        blank_tags;
    htcb_flags_t flags;
    char_t       ahead[3];
    int unsigned ahead_cnt;
    char_t       behind[2];
    int unsigned behind_cnt;

    initial begin
        mismatch_count = 0;
        beats_owed     = 0;
        fail_total     = 0;
    end

    // Decides one character; n0..n2 are the nla characters that follow it.
    function automatic char_t blank_char(char_t ch, char_t n0, char_t n1, char_t n2,
                                         int unsigned nla);
        logic  closed_tag = 1'b0;
        logic  closed_cmt = 1'b0;
        char_t res        = ch;
        if (!flags.cmt && !flags.sq && !flags.dq && !flags.tag && nla >= 3) begin
            if (ch == CH_LT && n0 == CH_BANG && n1 == CH_DASH && n2 == CH_DASH)
                flags.cmt = 1'b1;
        end else if (flags.cmt && behind_cnt >= 2) begin
            if (ch == CH_GT && behind[0] == CH_DASH && behind[1] == CH_DASH) begin
                flags.cmt  = 1'b0;
                closed_cmt = 1'b1;
            end
        end
        if (!flags.sq && !flags.dq && !flags.cmt && !closed_cmt) begin
            if (!flags.tag && ch == CH_LT) begin
                flags.tag = 1'b1;
            end else if (flags.tag && ch == CH_GT) begin
                flags.tag  = 1'b0;
                closed_tag = 1'b1;
            end
        end
        if (!flags.cmt && !flags.dq && flags.tag && ch == CH_SQUOTE)
            flags.sq = ~flags.sq;
        if (!flags.cmt && !flags.sq && flags.tag && ch == CH_DQUOTE)
            flags.dq = ~flags.dq;
        if (blank_tags && (flags.tag || closed_tag))
            res = CH_SPACE;
        if (flags.cmt || closed_cmt)
            res = CH_SPACE;
        behind[1] = behind[0];
        behind[0] = ch;
        if (behind_cnt < 2)
            behind_cnt++;
        return res;
    endfunction

    function automatic void clear_text();
        flags      = '0;
        ahead_cnt  = 0;
        behind_cnt = 0;
    endfunction

    // Queues the result beats that one accepted character releases.
    function automatic void predict_beats(char_t code, logic last);
        char_t       q[4];
        int unsigned m;
        char_t       res;
        out_beat_t   beat;
        for (int k = 0; k < 4; k++)
            q[k] = (k < ahead_cnt) ? ahead[k] : code;
        m = ahead_cnt + 1;
        if (!last) begin
            if (m <= 3) begin
                ahead[ahead_cnt] = code;
                ahead_cnt = m;
            end else begin
                res = blank_char(q[0], q[1], q[2], q[3], 3);
                beat.code = res;
                beat.last = 1'b0;
                owed_q.insert(owed_q.size(), beat);
                ahead[0] = q[1];
                ahead[1] = q[2];
                ahead[2] = q[3];
            end
        end else begin
            // End of text drains everything, then the parser starts afresh.
            for (int unsigned k = 0; k < m; k++) begin
                res = blank_char(q[k], q[(k + 1) % 4], q[(k + 2) % 4], q[(k + 3) % 4],
                                 m - 1 - k);
                beat.code = res;
                beat.last = (k + 1 == m);
                owed_q.insert(owed_q.size(), beat);
            end
            clear_text();
        end
    endfunction

    function automatic void note_mismatch(string what, out_beat_t want);
        fail_total++;
        if (fail_total <= 10)
            $display("%t: %s: expected code %h last %b, got code %h last %b",
                     $realtime, what, want.code, want.last, m_tdata, m_tlast);
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            blank_tags = 1'b1;
            clear_text();
            owed_q.delete();
        end else begin
            // Results are compared before the same edge's input is predicted,
            // so a fresh prediction can never hide a stray result.
            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    note_mismatch("result beat with nothing owed", '0);
                end else begin
                    want = owed_q.pop_front();
                    if (m_tdata !== want.code || m_tlast !== want.last)
                        note_mismatch("result mismatch", want);
                end
            end
            if (cfg_valid && cfg_ready)
                blank_tags = cfg_data;
            if (s_tvalid && s_tready)
                predict_beats(s_tdata, s_tlast);
        end
        mismatch_count <= fail_total;
        beats_owed     <= owed_q.size();
    end

endmodule

>>> test/tb.sv
// Testbench top for html_tag_comment_blanker_unit: drives character texts and
// register writes, stalls the result side, and reports the verdict.
// Depends on htcb_pkg, the block and html_tag_comment_blanker_checker.
`timescale 1ns / 100ps

module tb;
    import htcb_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 10;
    localparam int TARGET_CHARS = 300;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_ready;
    int          mismatch_count;
    int          beats_owed;

    int          chars_sent  = 0;
    int          burst_left  = 0;
    int          quiet_count = 0;
    int          hold_asked  = 0;
    int          hold_taken  = 0;
    int          hold_left   = 0;
    int          rx_style    = 0;
    int          style_left  = 0;
    char_t       text_q[$];

    always #1 aclk = ~aclk;

    html_tag_comment_blanker_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    html_tag_comment_blanker_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatch_count(mismatch_count), .beats_owed(beats_owed)
    );

    // Any accepted beat on any channel counts as progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side: changing stall styles, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= (style_left % 5 != 0);
            endcase
        end
    end

    task automatic send_char(input char_t code, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_str(input string s, input logic ends_text);
        for (int i = 0; i < s.len(); i++)
            send_char({8'h00, s[i]}, ends_text && (i == s.len() - 1));
    endtask

    task automatic send_text_q();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    // The register may only change once every owed result has come out.
    task automatic write_blank_tags(input logic value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_owed != 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic char_t letter();
        return char_t'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic char_t markup_char();
        case ($urandom_range(0, 8))
            0: return CH_LT;
            1: return CH_GT;
            2: return CH_BANG;
            3, 4: return CH_DASH;
            5: return CH_SQUOTE;
            6: return CH_DQUOTE;
            7: return char_t'($urandom_range(0, 16'hFFFF));
            default: return letter();
        endcase
    endfunction

    function automatic void put_char(char_t c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_char({8'h00, s[i]});
    endfunction

    // Builds a text from letters, comments and tags, with random
    // content, broken openers and stray markup mixed in.
    function automatic void build_text(int target_len);
        char_t quote;
        text_q.delete();
        while (text_q.size() < target_len) begin
            case ($urandom_range(0, 9))
                0, 1: repeat ($urandom_range(1, 4)) put_char(letter());
                2, 3: begin
                    add_str("<!--");
                    repeat ($urandom_range(0, 4)) put_char(markup_char());
                    if ($urandom_range(0, 4) != 0)
                        add_str("-->");
                end
                4, 5: begin
                    put_char(CH_LT);
                    repeat ($urandom_range(0, 3)) put_char(letter());
                    if ($urandom_range(0, 1) != 0) begin
                        quote = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
                        put_char(CH_SPACE);
                        put_char(quote);
                        repeat ($urandom_range(0, 3)) put_char(markup_char());
                        if ($urandom_range(0, 5) != 0)
                            put_char(quote);
                    end
                    put_char(CH_GT);
                end
                6: case ($urandom_range(0, 4))
                    0: add_str("<!-");
                    1: add_str("<!");
                    2: add_str("--");
                    3: add_str("->");
                    default: add_str("<-->");
                endcase
                7: put_char(($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE);
                8: repeat ($urandom_range(1, 3)) put_char(markup_char());
                default: put_char(char_t'($urandom_range(0, 16'hFFFF)));
            endcase
        end
    endfunction

    initial begin
        bit pressure_done;
        pressure_done = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed texts; blank_tags starts at its reset value of one.
        send_str("<!-->A", 1'b1);
        send_char(16'h0000, 1'b0);
        send_char(16'hFFFF, 1'b1);
        send_str("<'>'\">\">", 1'b1);
        write_blank_tags(1'b0);
        // A comment opener cut short by the end of text stays a plain tag.
        send_str("<b>", 1'b0);
        send_char(16'h0000, 1'b0);
        send_str("<!-", 1'b1);
        send_str(">", 1'b1);
        write_blank_tags(1'b1);

        while (chars_sent < TARGET_CHARS) begin
            if (!pressure_done && chars_sent > TARGET_CHARS / 2) begin
                // Hold the result side off while a long text keeps coming.
                pressure_done = 1'b1;
                hold_asked++;
                build_text(60);
            end else begin
                build_text(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                       : $urandom_range(5, 30));
            end
            send_text_q();
            if ($urandom_range(0, 3) == 0)
                write_blank_tags(1'($urandom_range(0, 1)));
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_owed != 0);
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && beats_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
